// ===== sv/fcve_pkg.sv =====
// shared types and constants of the front-coding vbyte encoder
`timescale 1ns / 1ps
`default_nettype none

package fcve_pkg;

    // default sizes, handed down through top-level parameters
    localparam int MAX_TERM_LEN_DEF = 31;
    localparam int MAX_GROUP_DEF    = 1024;

    // fixed field widths
    localparam int CHAR_W  = 8;
    localparam int PTR_W   = 63;
    localparam int DELTA_W = 64;
    localparam int CFG_W   = 11;

    // header nibble cap and vbyte digit layout
    localparam int PREFIX_CAP = 15;
    localparam int VB_BITS    = 7;

    // source of the byte loaded into the output register
    typedef enum logic [1:0] {
        SEL_HDR,
        SEL_SUF,
        SEL_TERM,
        SEL_VB
    } t_out_sel;

    // commands from the controller to the datapath
    typedef struct packed {
        logic     accept;
        logic     compare;
        logic     prep;
        logic     out_load;
        t_out_sel out_sel;
        logic     close;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic end_flag;
        logic gp_nonzero;
        logic suf_more;
        logic suf_more_next;
        logic long_term;
        logic delta_pos;
        logic delta_more;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== sv/fcve_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module fcve_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/fcve_ctrl.sv =====
// controller state machine of the front-coding vbyte encoder
`timescale 1ns / 1ps
`default_nettype none

module fcve_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire fcve_pkg::t_status i_status,
    output fcve_pkg::t_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CMP,
        S_PREP,
        S_HDR,
        S_SUF_RD,
        S_SUF_OUT,
        S_TERM,
        S_VB,
        S_CLOSE
    } t_state;

    t_state r_state;
    t_state n_state;
    fcve_pkg::t_cmd cmd;

    always_comb begin
        n_state      = r_state;
        cmd          = '0;
        cmd.out_sel  = fcve_pkg::SEL_HDR;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_CMP;
                end
            end
            S_CMP: begin
                cmd.compare = 1'b1;
                n_state     = i_status.end_flag ? S_PREP : S_IDLE;
            end
            S_PREP: begin
                cmd.prep = 1'b1;
                n_state  = i_status.gp_nonzero ? S_HDR : S_CLOSE;
            end
            S_HDR: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = fcve_pkg::SEL_HDR;
                    if (i_status.suf_more) begin
                        n_state = S_SUF_RD;
                    end else begin
                        n_state = i_status.long_term ? S_TERM : S_VB;
                    end
                end
            end
            S_SUF_RD: begin
                n_state = S_SUF_OUT;
            end
            S_SUF_OUT: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = fcve_pkg::SEL_SUF;
                    if (i_status.suf_more_next) begin
                        n_state = S_SUF_RD;
                    end else begin
                        n_state = i_status.long_term ? S_TERM : S_VB;
                    end
                end
            end
            S_TERM: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = fcve_pkg::SEL_TERM;
                    n_state      = S_VB;
                end
            end
            S_VB: begin
                if (i_status.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = fcve_pkg::SEL_VB;
                    if (!i_status.delta_pos || !i_status.delta_more) begin
                        n_state = S_CLOSE;
                    end
                end
            end
            S_CLOSE: begin
                cmd.close = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);

    // never overwrite a byte that the consumer has not taken
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> i_status.out_free)
        else $error("output register loaded while occupied");

endmodule

`default_nettype wire

// ===== sv/fcve_dp.sv =====
// datapath of the front-coding vbyte encoder: term buffers, counters, output register
`timescale 1ns / 1ps
`default_nettype none

module fcve_dp #(
    parameter int MAX_TERM_LEN = fcve_pkg::MAX_TERM_LEN_DEF,
    parameter int MAX_GROUP    = fcve_pkg::MAX_GROUP_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [fcve_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  wire logic [fcve_pkg::CHAR_W-1:0]  i_term_char,
    input  wire logic                         i_term_end,
    input  wire logic [fcve_pkg::PTR_W-1:0]   i_file_pointer,
    input  wire logic                         i_out_stall,
    output logic                              o_out_valid,
    output logic      [fcve_pkg::CHAR_W-1:0]  o_out_byte,
    output logic                              o_run_last,
    output logic                              o_order_error,
    input  wire fcve_pkg::t_cmd               i_cmd,
    output fcve_pkg::t_status                 o_status
);

    localparam int LW = $clog2(MAX_TERM_LEN + 1);
    localparam int AW = $clog2(MAX_TERM_LEN);
    localparam int GW = $clog2(MAX_GROUP);
    localparam int CW = fcve_pkg::CHAR_W;
    localparam int DW = fcve_pkg::DELTA_W;
    localparam int VB = fcve_pkg::VB_BITS;

    // captured request
    logic [CW-1:0]               r_char;
    logic                        r_end;
    logic [fcve_pkg::PTR_W-1:0]  r_fp;
    logic                        r_stored;

    // term tracking
    logic [LW-1:0] r_cur_len;
    logic [LW-1:0] r_ref_len;
    logic [LW-1:0] r_prefix;
    logic          r_still;
    logic          r_bank;
    logic [fcve_pkg::PTR_W-1:0] r_ref_ptr;
    logic [GW-1:0] r_gp;
    logic [fcve_pkg::CFG_W-1:0] r_grp_terms;

    // emission context
    logic [3:0]    r_m;
    logic [3:0]    r_suf_nib;
    logic          r_long;
    logic [LW-1:0] r_idx;
    logic [DW-1:0] r_delta;
    logic          r_pos;

    // output register
    logic          r_out_valid;
    logic [CW-1:0] r_out_byte;
    logic          r_run_last;
    logic          r_order_err;

    logic          store_now;
    logic          wr0;
    logic          wr1;
    logic [AW-1:0] raddr0;
    logic [AW-1:0] raddr1;
    logic [CW-1:0] rdata0;
    logic [CW-1:0] rdata1;
    logic [CW-1:0] cur_rdata;
    logic [CW-1:0] ref_rdata;
    logic [3:0]    m_cap;
    logic [LW-1:0] suf_len;
    logic [LW:0]   idx_next;
    logic [GW:0]   gp_next;
    logic [31:0]   gs_eff;
    logic          gp_wrap;
    logic          out_free;
    logic [CW-1:0] load_byte;
    logic          load_last;
    logic          load_err;

    assign store_now = (i_term_char != '0) && (r_cur_len < LW'(MAX_TERM_LEN));
    assign wr0       = i_cmd.accept && store_now && !r_bank;
    assign wr1       = i_cmd.accept && store_now &&  r_bank;

    // bank r_bank holds the term being built, the other one the reference
    assign raddr0    = r_bank ? r_cur_len[AW-1:0] : r_idx[AW-1:0];
    assign raddr1    = r_bank ? r_idx[AW-1:0]     : r_cur_len[AW-1:0];
    assign cur_rdata = r_bank ? rdata1 : rdata0;
    assign ref_rdata = r_bank ? rdata0 : rdata1;

    fcve_ram #(.WIDTH(CW), .DEPTH(MAX_TERM_LEN)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (wr0),
        .i_waddr (r_cur_len[AW-1:0]),
        .i_wdata (i_term_char),
        .i_raddr (raddr0),
        .o_rdata (rdata0)
    );

    fcve_ram #(.WIDTH(CW), .DEPTH(MAX_TERM_LEN)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (wr1),
        .i_waddr (r_cur_len[AW-1:0]),
        .i_wdata (i_term_char),
        .i_raddr (raddr1),
        .o_rdata (rdata1)
    );

    assign m_cap    = (r_prefix > LW'(fcve_pkg::PREFIX_CAP)) ? 4'(fcve_pkg::PREFIX_CAP)
                                                             : r_prefix[3:0];
    assign suf_len  = r_cur_len - LW'(m_cap);
    assign idx_next = {1'b0, r_idx} + (LW+1)'(1);

    // group position wraps at the clamped group size
    assign gp_next = {1'b0, r_gp} + (GW+1)'(1);
    always_comb begin
        gs_eff = 32'(r_grp_terms);
        if (gs_eff == 32'd0) begin
            gs_eff = 32'd1;
        end else if (gs_eff > 32'(MAX_GROUP)) begin
            gs_eff = 32'(MAX_GROUP);
        end
    end
    assign gp_wrap = (32'(gp_next) >= gs_eff);

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        load_byte = '0;
        load_last = 1'b0;
        load_err  = 1'b0;
        unique case (i_cmd.out_sel)
            fcve_pkg::SEL_HDR:  load_byte = {r_m, (r_long ? 4'h0 : r_suf_nib)};
            fcve_pkg::SEL_SUF:  load_byte = cur_rdata;
            fcve_pkg::SEL_TERM: load_byte = '0;
            fcve_pkg::SEL_VB: begin
                if (!r_pos) begin
                    load_byte = r_delta[CW-1:0];
                    load_last = 1'b1;
                    load_err  = 1'b1;
                end else if (|r_delta[DW-1:VB]) begin
                    load_byte = {1'b1, r_delta[VB-1:0]};
                end else begin
                    load_byte = {1'b0, r_delta[VB-1:0]};
                    load_last = 1'b1;
                end
            end
            default: load_byte = '0;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_len    <= '0;
            r_ref_len    <= '0;
            r_prefix     <= '0;
            r_still      <= 1'b1;
            r_bank       <= 1'b0;
            r_ref_ptr    <= '0;
            r_gp         <= '0;
            r_grp_terms  <= fcve_pkg::CFG_W'(1);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_grp_terms <= i_cfg_wdata;
            end
            if (i_cmd.compare && r_stored) begin
                if (r_still && (r_cur_len < r_ref_len) && (ref_rdata == r_char)) begin
                    r_prefix <= r_prefix + LW'(1);
                end else begin
                    r_still <= 1'b0;
                end
                r_cur_len <= r_cur_len + LW'(1);
            end
            if (i_cmd.close) begin
                r_ref_len <= r_cur_len;
                r_ref_ptr <= r_fp;
                r_bank    <= ~r_bank;
                r_cur_len <= '0;
                r_prefix  <= '0;
                r_still   <= 1'b1;
                r_gp      <= gp_wrap ? '0 : gp_next[GW-1:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_char   <= i_term_char;
            r_end    <= i_term_end;
            r_fp     <= i_file_pointer;
            r_stored <= store_now;
        end
        if (i_cmd.prep) begin
            r_m       <= m_cap;
            r_suf_nib <= suf_len[3:0];
            r_long    <= (suf_len > LW'(fcve_pkg::PREFIX_CAP));
            r_idx     <= LW'(m_cap);
            r_delta   <= {1'b0, r_fp} - {1'b0, r_ref_ptr};
            r_pos     <= (r_fp > r_ref_ptr);
        end
        if (i_cmd.out_load) begin
            r_out_byte  <= load_byte;
            r_run_last  <= load_last;
            r_order_err <= load_err;
            if (i_cmd.out_sel == fcve_pkg::SEL_SUF) begin
                r_idx <= idx_next[LW-1:0];
            end
            if (i_cmd.out_sel == fcve_pkg::SEL_VB) begin
                r_delta <= r_delta >> VB;
            end
        end
    end

    assign o_status.end_flag      = r_end;
    assign o_status.gp_nonzero    = (r_gp != '0);
    assign o_status.suf_more      = (r_idx < r_cur_len);
    assign o_status.suf_more_next = (idx_next < {1'b0, r_cur_len});
    assign o_status.long_term     = r_long;
    assign o_status.delta_pos     = r_pos;
    assign o_status.delta_more    = |r_delta[DW-1:VB];
    assign o_status.out_free      = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_run_last    = r_run_last;
    assign o_order_error = r_order_err;

    a_prefix_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_prefix <= r_cur_len)
        else $error("prefix match exceeds term length");

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_order_err |-> r_run_last)
        else $error("order error byte is not the final byte of the term");

    a_suffix_in_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && (i_cmd.out_sel == fcve_pkg::SEL_SUF) |-> r_idx < r_cur_len)
        else $error("suffix read beyond the term");

endmodule

`default_nettype wire

// ===== sv/front_coding_vbyte_encoder.sv =====
// top level of the front-coding dictionary encoder with vbyte pointer deltas
`timescale 1ns / 1ps
`default_nettype none

// Sorted dictionary terms enter one character per request; the request with
// i_term_end closes the term and carries its file pointer. Terms are counted
// into groups of the configured size; the first term of a group only becomes
// the reference and produces no bytes. Every later term produces a header byte
// (shared prefix capped at 15 in the high nibble, suffix length or 0 for a long
// suffix in the low nibble), the suffix characters, a zero terminator for a
// long suffix, and the pointer delta as little-endian vbyte with o_run_last on
// its final byte; a nonpositive delta gives one byte with o_order_error set.
// Each character passes an accept and a compare state, as the prefix compare
// waits on the registered read of the reference term buffer. Closing a term
// adds bookkeeping prep and close states; when bytes are emitted, the header,
// each suffix byte (registered buffer read, then output load), the terminator
// and each vbyte byte come between them, all stretched by output stalls. The
// current and reference terms live in two small rams that swap roles at every
// term end, so no copy pass is needed. Write group size only while idle.

module front_coding_vbyte_encoder #(
    parameter int MAX_TERM_LEN = fcve_pkg::MAX_TERM_LEN_DEF,
    parameter int MAX_GROUP    = fcve_pkg::MAX_GROUP_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration: group size
    input  wire logic                         i_cfg_we,
    input  wire logic [fcve_pkg::CFG_W-1:0]   i_cfg_wdata,
    // input channel
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [fcve_pkg::CHAR_W-1:0]  i_term_char,
    input  wire logic                         i_term_end,
    input  wire logic [fcve_pkg::PTR_W-1:0]   i_file_pointer,
    // output channel
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [fcve_pkg::CHAR_W-1:0]  o_out_byte,
    output logic                              o_run_last,
    output logic                              o_order_error
);

    // command and status between sequencer and datapath
    fcve_pkg::t_cmd    cmd;
    fcve_pkg::t_status status;

    // sequencer: character accept, compare, term close and byte emission
    fcve_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: term buffers, prefix tracking, delta, group counter, output register
    fcve_dp #(
        .MAX_TERM_LEN (MAX_TERM_LEN),
        .MAX_GROUP    (MAX_GROUP)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_term_char    (i_term_char),
        .i_term_end     (i_term_end),
        .i_file_pointer (i_file_pointer),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_order_error  (o_order_error),
        .i_cmd          (cmd),
        .o_status       (status)
    );

endmodule

`default_nettype wire
